>>> design/rpc_pkg.sv
// rpc_pkg: shared widths, pose layout and register codes for the pose composer
`timescale 1ns / 1ps

package rpc_pkg;

	// fixed field widths of the stream payload
	localparam int TRANS_W   = 32;
	localparam int QUAT_W    = 16;

	// register stages from input beat to output register
	localparam int STAGES    = 6;

	// configuration index width
	localparam int CFG_IDX_W = 3;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_TX = 3'd0,
		REG_ORIGIN_TY = 3'd1,
		REG_ORIGIN_TZ = 3'd2,
		REG_ORIGIN_QX = 3'd3,
		REG_ORIGIN_QY = 3'd4,
		REG_ORIGIN_QZ = 3'd5,
		REG_ORIGIN_QW = 3'd6
	} cfg_reg_t;

	// one pose, first member in the highest bits so tx sits at bit 0
	typedef struct packed {
		logic signed [QUAT_W-1:0]  qw;
		logic signed [QUAT_W-1:0]  qz;
		logic signed [QUAT_W-1:0]  qy;
		logic signed [QUAT_W-1:0]  qx;
		logic signed [TRANS_W-1:0] tz;
		logic signed [TRANS_W-1:0] ty;
		logic signed [TRANS_W-1:0] tx;
	} pose_t;

	// base pose after reset: no offset, identity rotation
	localparam pose_t ORIGIN_RESET = '{
		qw: 16'sd16384,
		default: '0
	};

endpackage

>>> design/rpc_rotate.sv
// rpc_rotate: pipelined sandwich rotation q v conj(q) plus base offset, saturated
`timescale 1ns / 1ps

module rpc_rotate #(
	parameter int QUAT_FRAC_BITS = 14,
	parameter int TRANS_WIDTH    = 32
) (
	input  logic                                 clk,
	input  logic [rpc_pkg::STAGES-1:0]           load,
	input  rpc_pkg::pose_t                       origin,
	input  logic signed [rpc_pkg::TRANS_W-1:0]   vec_tx,
	input  logic signed [rpc_pkg::TRANS_W-1:0]   vec_ty,
	input  logic signed [rpc_pkg::TRANS_W-1:0]   vec_tz,
	output logic signed [rpc_pkg::TRANS_W-1:0]   out_tx,
	output logic signed [rpc_pkg::TRANS_W-1:0]   out_ty,
	output logic signed [rpc_pkg::TRANS_W-1:0]   out_tz,
	output logic                                 sat
);

	localparam int PROD1_W = rpc_pkg::TRANS_W + rpc_pkg::QUAT_W;
	localparam int ACC1_W  = PROD1_W + 3;
	localparam int P_W     = ACC1_W - QUAT_FRAC_BITS;
	localparam int PROD2_W = P_W + rpc_pkg::QUAT_W;
	localparam int ACC2_W  = PROD2_W + 3;
	localparam int RR_W    = ACC2_W - QUAT_FRAC_BITS;
	localparam int ADD_W   = (RR_W > rpc_pkg::TRANS_W ? RR_W : rpc_pkg::TRANS_W) + 1;
	localparam int SAT_W   = (ADD_W > TRANS_WIDTH ? ADD_W : TRANS_WIDTH + 1);

	localparam logic signed [ACC1_W-1:0] HALF1 = ACC1_W'(64'sd1 <<< (QUAT_FRAC_BITS - 1));
	localparam logic signed [ACC2_W-1:0] HALF2 = ACC2_W'(64'sd1 <<< (QUAT_FRAC_BITS - 1));
	localparam logic signed [SAT_W-1:0]  TMAX  =
		SAT_W'((64'sd1 <<< (TRANS_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SAT_W-1:0]  TMIN  = SAT_W'(-(64'sd1 <<< (TRANS_WIDTH - 1)));

	logic signed [rpc_pkg::QUAT_W-1:0]  qx, qy, qz, qw;
	logic signed [rpc_pkg::TRANS_W-1:0] bt [3];

	logic signed [PROD1_W-1:0] m1_s1 [12];
	logic signed [ACC1_W-1:0]  acc1 [4];
	logic signed [P_W-1:0]     p_s2 [4];
	logic signed [PROD2_W-1:0] m2_s3 [12];
	logic signed [ACC2_W-1:0]  acc2 [3];
	logic signed [RR_W-1:0]    rr_s4 [3];
	logic signed [ADD_W-1:0]   sum_s5 [3];
	logic signed [SAT_W-1:0]   sum_ext [3];
	logic signed [SAT_W-1:0]   clip [3];
	logic [2:0]                clip_hit;
	logic signed [rpc_pkg::TRANS_W-1:0] out_s6 [3];
	logic                      sat_s6;

	assign qx = origin.qx;
	assign qy = origin.qy;
	assign qz = origin.qz;
	assign qw = origin.qw;
	assign bt[0] = origin.tx;
	assign bt[1] = origin.ty;
	assign bt[2] = origin.tz;

	// stage 1: products of base quaternion and input vector
	always_ff @(posedge clk) begin
		if (load[0]) begin
			m1_s1[0]  <= qw * vec_tx;
			m1_s1[1]  <= qy * vec_tz;
			m1_s1[2]  <= qz * vec_ty;
			m1_s1[3]  <= qw * vec_ty;
			m1_s1[4]  <= qz * vec_tx;
			m1_s1[5]  <= qx * vec_tz;
			m1_s1[6]  <= qw * vec_tz;
			m1_s1[7]  <= qx * vec_ty;
			m1_s1[8]  <= qy * vec_tx;
			m1_s1[9]  <= qx * vec_tx;
			m1_s1[10] <= qy * vec_ty;
			m1_s1[11] <= qz * vec_tz;
		end
	end

	// stage 2: first half of the sandwich, rounded back to translation scale
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc1[i] = ACC1_W'(m1_s1[3*i]) + ACC1_W'(m1_s1[3*i+1])
				- ACC1_W'(m1_s1[3*i+2]) + HALF1;
		end
		acc1[3] = HALF1 - ACC1_W'(m1_s1[9]) - ACC1_W'(m1_s1[10]) - ACC1_W'(m1_s1[11]);
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			for (int i = 0; i < 4; i++) begin
				p_s2[i] <= P_W'(acc1[i] >>> QUAT_FRAC_BITS);
			end
		end
	end

	// stage 3: products with the conjugate (signs folded into the sums)
	always_ff @(posedge clk) begin
		if (load[2]) begin
			m2_s3[0]  <= p_s2[3] * qx;
			m2_s3[1]  <= p_s2[0] * qw;
			m2_s3[2]  <= p_s2[1] * qz;
			m2_s3[3]  <= p_s2[2] * qy;
			m2_s3[4]  <= p_s2[3] * qy;
			m2_s3[5]  <= p_s2[1] * qw;
			m2_s3[6]  <= p_s2[2] * qx;
			m2_s3[7]  <= p_s2[0] * qz;
			m2_s3[8]  <= p_s2[3] * qz;
			m2_s3[9]  <= p_s2[2] * qw;
			m2_s3[10] <= p_s2[0] * qy;
			m2_s3[11] <= p_s2[1] * qx;
		end
	end

	// stage 4: vector part of the sandwich, rounded
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc2[i] = HALF2 - ACC2_W'(m2_s3[4*i]) + ACC2_W'(m2_s3[4*i+1])
				- ACC2_W'(m2_s3[4*i+2]) + ACC2_W'(m2_s3[4*i+3]);
		end
	end

	always_ff @(posedge clk) begin
		if (load[3]) begin
			for (int i = 0; i < 3; i++) begin
				rr_s4[i] <= RR_W'(acc2[i] >>> QUAT_FRAC_BITS);
			end
		end
	end

	// stage 5: add the base offset at full width
	always_ff @(posedge clk) begin
		if (load[4]) begin
			for (int i = 0; i < 3; i++) begin
				sum_s5[i] <= ADD_W'(rr_s4[i]) + ADD_W'(bt[i]);
			end
		end
	end

	// stage 6: saturate to the translation range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_ext[i] = SAT_W'(sum_s5[i]);
			if (sum_ext[i] > TMAX) begin
				clip[i]     = TMAX;
				clip_hit[i] = 1'b1;
			end else if (sum_ext[i] < TMIN) begin
				clip[i]     = TMIN;
				clip_hit[i] = 1'b1;
			end else begin
				clip[i]     = sum_ext[i];
				clip_hit[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[5]) begin
			for (int i = 0; i < 3; i++) begin
				out_s6[i] <= clip[i][rpc_pkg::TRANS_W-1:0];
			end
			sat_s6 <= |clip_hit;
		end
	end

	assign out_tx = out_s6[0];
	assign out_ty = out_s6[1];
	assign out_tz = out_s6[2];
	assign sat    = sat_s6;

endmodule

>>> design/rpc_qmul.sv
// rpc_qmul: pipelined Hamilton product of base and input quaternions, rounded and clamped
`timescale 1ns / 1ps

module rpc_qmul #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic [rpc_pkg::STAGES-1:0]          load,
	input  rpc_pkg::pose_t                      origin,
	input  logic signed [rpc_pkg::QUAT_W-1:0]   in_qx,
	input  logic signed [rpc_pkg::QUAT_W-1:0]   in_qy,
	input  logic signed [rpc_pkg::QUAT_W-1:0]   in_qz,
	input  logic signed [rpc_pkg::QUAT_W-1:0]   in_qw,
	output logic signed [rpc_pkg::QUAT_W-1:0]   out_qx,
	output logic signed [rpc_pkg::QUAT_W-1:0]   out_qy,
	output logic signed [rpc_pkg::QUAT_W-1:0]   out_qz,
	output logic signed [rpc_pkg::QUAT_W-1:0]   out_qw,
	output logic                                sat
);

	localparam int PROD_W = 2 * rpc_pkg::QUAT_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int QR_W   = ACC_W - QUAT_FRAC_BITS;
	localparam int QC_A   = (QR_W > QUAT_FRAC_BITS + 2 ? QR_W : QUAT_FRAC_BITS + 2);
	localparam int QC_W   = (QC_A > rpc_pkg::QUAT_W ? QC_A : rpc_pkg::QUAT_W);

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (QUAT_FRAC_BITS - 1));
	localparam logic signed [QC_W-1:0]  QLIM = QC_W'(64'sd1 <<< QUAT_FRAC_BITS);

	logic signed [rpc_pkg::QUAT_W-1:0] ax, ay, az, aw;

	logic signed [PROD_W-1:0]          m_s1 [16];
	logic signed [ACC_W-1:0]           acc [4];
	logic signed [QR_W-1:0]            qr_s2 [4];
	logic signed [QC_W-1:0]            qr_ext [4];
	logic signed [QC_W-1:0]            clip [4];
	logic [3:0]                        clip_hit;
	logic signed [rpc_pkg::QUAT_W-1:0] q_s3 [4];
	logic signed [rpc_pkg::QUAT_W-1:0] q_s4 [4];
	logic signed [rpc_pkg::QUAT_W-1:0] q_s5 [4];
	logic signed [rpc_pkg::QUAT_W-1:0] q_s6 [4];
	logic                              sat_s3, sat_s4, sat_s5, sat_s6;

	assign ax = origin.qx;
	assign ay = origin.qy;
	assign az = origin.qz;
	assign aw = origin.qw;

	// stage 1: the sixteen partial products
	always_ff @(posedge clk) begin
		if (load[0]) begin
			m_s1[0]  <= aw * in_qx;
			m_s1[1]  <= ax * in_qw;
			m_s1[2]  <= ay * in_qz;
			m_s1[3]  <= az * in_qy;
			m_s1[4]  <= aw * in_qy;
			m_s1[5]  <= ay * in_qw;
			m_s1[6]  <= az * in_qx;
			m_s1[7]  <= ax * in_qz;
			m_s1[8]  <= aw * in_qz;
			m_s1[9]  <= az * in_qw;
			m_s1[10] <= ax * in_qy;
			m_s1[11] <= ay * in_qx;
			m_s1[12] <= aw * in_qw;
			m_s1[13] <= ax * in_qx;
			m_s1[14] <= ay * in_qy;
			m_s1[15] <= az * in_qz;
		end
	end

	// stage 2: signed sums with half lsb, rounded
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(m_s1[4*i]) + ACC_W'(m_s1[4*i+1]) + ACC_W'(m_s1[4*i+2])
				- ACC_W'(m_s1[4*i+3]) + HALF;
		end
		acc[3] = ACC_W'(m_s1[12]) - ACC_W'(m_s1[13]) - ACC_W'(m_s1[14])
			- ACC_W'(m_s1[15]) + HALF;
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			for (int i = 0; i < 4; i++) begin
				qr_s2[i] <= QR_W'(acc[i] >>> QUAT_FRAC_BITS);
			end
		end
	end

	// stage 3: clamp to plus or minus one
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qr_ext[i] = QC_W'(qr_s2[i]);
			if (qr_ext[i] > QLIM) begin
				clip[i]     = QLIM;
				clip_hit[i] = 1'b1;
			end else if (qr_ext[i] < -QLIM) begin
				clip[i]     = -QLIM;
				clip_hit[i] = 1'b1;
			end else begin
				clip[i]     = qr_ext[i];
				clip_hit[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			for (int i = 0; i < 4; i++) begin
				q_s3[i] <= clip[i][rpc_pkg::QUAT_W-1:0];
			end
			sat_s3 <= |clip_hit;
		end
	end

	// stages 4 to 6: delay to line up with the translation path
	always_ff @(posedge clk) begin
		if (load[3]) begin
			q_s4   <= q_s3;
			sat_s4 <= sat_s3;
		end
		if (load[4]) begin
			q_s5   <= q_s4;
			sat_s5 <= sat_s4;
		end
		if (load[5]) begin
			q_s6   <= q_s5;
			sat_s6 <= sat_s5;
		end
	end

	assign out_qx = q_s6[0];
	assign out_qy = q_s6[1];
	assign out_qz = q_s6[2];
	assign out_qw = q_s6[3];
	assign sat    = sat_s6;

endmodule

>>> design/rigid_pose_compose.sv
// rigid_pose_compose: top level, composes a configured base pose with a stream of poses
//
//   channel  direction  beat content (lowest bits first)
//   cfg      in         cfg_addr selects register, cfg_wdata value, cfg_we strobe
//   s_axis   in         tx ty tz qx qy qz qw
//   m_axis   out        tx ty tz qx qy qz qw, tuser: saturated
//
// one beat per cycle in and out while m_tready is high; a beat passes the two multiply
// stages of the rotation sandwich, each followed by an add-and-round stage,
// then the offset add and the saturation/output register.
// each stage holds its own valid bit and loads when it is empty or the next one
// moves, so a stall on m_tready only backs up as far as there are full stages.
// reset clears the valid bits and loads the base pose with zero offset and
// identity rotation; the datapath registers are not reset.
`timescale 1ns / 1ps

module rigid_pose_compose #(
	parameter int QUAT_FRAC_BITS = 14,
	parameter int TRANS_WIDTH    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpc_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [rpc_pkg::TRANS_W-1:0]         cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tx, ty, tz (32 each), qx, qy, qz, qw (16 each)
	input  logic [$bits(rpc_pkg::pose_t)-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tx, ty, tz (32 each), qx, qy, qz, qw (16 each)
	output logic [$bits(rpc_pkg::pose_t)-1:0]   m_tdata,
	// saturated
	output logic                                m_tuser
);

	rpc_pkg::pose_t                origin_q;
	rpc_pkg::pose_t                in_pose;
	rpc_pkg::pose_t                out_pose;
	logic [rpc_pkg::STAGES-1:0]    stage_vld_q;
	logic [rpc_pkg::STAGES-1:0]    load;
	logic                          rot_sat;
	logic                          quat_sat;

	// base pose registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= rpc_pkg::ORIGIN_RESET;
		end else if (cfg_we) begin
			unique case (rpc_pkg::cfg_reg_t'(cfg_addr))
				rpc_pkg::REG_ORIGIN_TX: origin_q.tx <= cfg_wdata;
				rpc_pkg::REG_ORIGIN_TY: origin_q.ty <= cfg_wdata;
				rpc_pkg::REG_ORIGIN_TZ: origin_q.tz <= cfg_wdata;
				rpc_pkg::REG_ORIGIN_QX: origin_q.qx <= cfg_wdata[rpc_pkg::QUAT_W-1:0];
				rpc_pkg::REG_ORIGIN_QY: origin_q.qy <= cfg_wdata[rpc_pkg::QUAT_W-1:0];
				rpc_pkg::REG_ORIGIN_QZ: origin_q.qz <= cfg_wdata[rpc_pkg::QUAT_W-1:0];
				rpc_pkg::REG_ORIGIN_QW: origin_q.qw <= cfg_wdata[rpc_pkg::QUAT_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage load: stage empty or its successor moving
	always_comb begin
		load[rpc_pkg::STAGES-1] = !stage_vld_q[rpc_pkg::STAGES-1] || m_tready;
		for (int k = rpc_pkg::STAGES - 2; k >= 0; k--) begin
			load[k] = !stage_vld_q[k] || load[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (load[0]) begin
				stage_vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < rpc_pkg::STAGES; k++) begin
				if (load[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = load[0];
	assign m_tvalid = stage_vld_q[rpc_pkg::STAGES-1];
	assign in_pose  = rpc_pkg::pose_t'(s_tdata);

	// translation path
	rpc_rotate #(
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS),
		.TRANS_WIDTH    (TRANS_WIDTH)
	) u_rotate (
		.clk    (clk),
		.load   (load),
		.origin (origin_q),
		.vec_tx (in_pose.tx),
		.vec_ty (in_pose.ty),
		.vec_tz (in_pose.tz),
		.out_tx (out_pose.tx),
		.out_ty (out_pose.ty),
		.out_tz (out_pose.tz),
		.sat    (rot_sat)
	);

	// rotation path
	rpc_qmul #(
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_qmul (
		.clk    (clk),
		.load   (load),
		.origin (origin_q),
		.in_qx  (in_pose.qx),
		.in_qy  (in_pose.qy),
		.in_qz  (in_pose.qz),
		.in_qw  (in_pose.qw),
		.out_qx (out_pose.qx),
		.out_qy (out_pose.qy),
		.out_qz (out_pose.qz),
		.out_qw (out_pose.qw),
		.sat    (quat_sat)
	);

	assign m_tdata = out_pose;
	assign m_tuser = rot_sat | quat_sat;

endmodule

>>> design/rpc_checker.sv
// rpc_checker: port-level checks on the pose composer, bound to the top level
`timescale 1ns / 1ps

module rpc_checker #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [$bits(rpc_pkg::pose_t)-1:0] m_tdata,
	input logic                              m_tuser
);

	localparam int QLIM = 1 << QUAT_FRAC_BITS;

	rpc_pkg::pose_t out_pose;

	assign out_pose = rpc_pkg::pose_t'(m_tdata);

	// a held output beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// an accepted beat shows at the output once it has passed every pipeline stage
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##6 m_tvalid)
		else $error("accepted beat did not reach the output in time");

	// input back-pressure only when the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with the output free");

	// quaternion components stay clamped to plus or minus one (checked for QUAT_FRAC_BITS up to 14)
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (QUAT_FRAC_BITS > 14) ||
			(out_pose.qx <= QLIM && out_pose.qx >= -QLIM &&
			 out_pose.qy <= QLIM && out_pose.qy >= -QLIM &&
			 out_pose.qz <= QLIM && out_pose.qz >= -QLIM &&
			 out_pose.qw <= QLIM && out_pose.qw >= -QLIM))
		else $error("quaternion component beyond clamp range");

	// nothing valid at the output while in reset
	assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind rigid_pose_compose rpc_checker #(
	.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
) u_rpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
